@@ hw/rtl/rc4_pkg.sv @@
// ---------------------------------------------------------------------------
// RC4 stream cipher package
// Shared widths, sizes and command codes for the RC4 block.
// ---------------------------------------------------------------------------
package rc4_pkg;

    // Width of one byte item and of one permutation entry.
    localparam int BYTE_W = 8;

    // Number of entries in the RC4 permutation.
    localparam int PERM_SIZE = 256;

    // Default upper bound on the number of stored key bytes.
    localparam int KEY_MAX_DEFAULT = 256;

    // Command codes carried on the cmd field.
    typedef enum logic [0:0] {
        CMD_KEY  = 1'b0,
        CMD_DATA = 1'b1
    } cmd_t;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage

@@ hw/rtl/rc4_ram.sv @@
// ---------------------------------------------------------------------------
// RC4 single-port-write RAM
// One write port and one read port with registered read data. Used for the
// permutation and for the key bytes.
// ---------------------------------------------------------------------------
module rc4_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; a read in the same cycle as a write returns the old data.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/rc4_stream_cipher.sv @@
// ---------------------------------------------------------------------------
// RC4 stream cipher
// Stores key bytes, runs the RC4 key schedule on the last key byte and XORs
// each data byte with the RC4 keystream. All permutation accesses go through
// one RAM with one read and one write port under a small sequencer.
// ---------------------------------------------------------------------------
// Data byte: accepted in idle, then read and swapped in S_DRD1, S_DRD2, S_DWR1
// and S_DWR2, then loaded into the output register from S_OUT once it is free.
// One byte at a time. Data before any key goes straight to S_OUT and returns the byte with no_key set.
// Last key byte: S_INIT writes the identity permutation, then 256 schedule steps
// run through S_KRD1, S_KRD2, S_KWR1 and S_KWR2; not ready meanwhile.
// Reset (rst_n low, asynchronous) clears the sequencer, indices, key count and
// the keyed flag; the permutation is rebuilt by every key schedule before use.
// ---------------------------------------------------------------------------
module rc4_stream_cipher #(
    parameter int KEY_MAX_BYTES = rc4_pkg::KEY_MAX_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       cmd,
    input  logic [rc4_pkg::BYTE_W-1:0] byte_in,
    input  logic                       key_last,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [rc4_pkg::BYTE_W-1:0] data_out,
    output logic                       no_key
);

    import rc4_pkg::*;

    localparam int PIDX_W = $clog2(PERM_SIZE);
    localparam int KIDX_W = $clog2(KEY_MAX_BYTES);
    localparam int KCNT_W = KIDX_W + 1;
    localparam logic [KCNT_W-1:0] KEY_MAX = KCNT_W'(KEY_MAX_BYTES);
    localparam logic [PIDX_W-1:0] PIDX_LAST = PIDX_W'(PERM_SIZE - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_KRD1,
        S_KRD2,
        S_KWR1,
        S_KWR2,
        S_DRD1,
        S_DRD2,
        S_DWR1,
        S_DWR2,
        S_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [KCNT_W-1:0]   key_count_reg, key_count_next;
    logic [KIDX_W-1:0]   kidx_reg, kidx_next;
    logic [PIDX_W-1:0]   n_reg, n_next;
    logic [BYTE_W-1:0]   acc_reg, acc_next;
    logic [BYTE_W-1:0]   i_reg, i_next;
    logic [BYTE_W-1:0]   j_reg, j_next;
    logic [BYTE_W-1:0]   t_reg, t_next;
    logic [BYTE_W-1:0]   si_reg, si_next;
    logic [BYTE_W-1:0]   sj_reg, sj_next;
    logic [BYTE_W-1:0]   b_reg, b_next;
    logic [BYTE_W-1:0]   res_reg, res_next;
    logic                res_nokey_reg, res_nokey_next;
    logic                keyed_reg, keyed_next;
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   data_out_reg, data_out_next;
    logic                no_key_reg, no_key_next;

    logic                perm_we;
    logic [PIDX_W-1:0]   perm_waddr;
    logic [BYTE_W-1:0]   perm_wdata;
    logic [PIDX_W-1:0]   perm_raddr;
    logic [BYTE_W-1:0]   perm_rdata;

    logic                key_we;
    logic [KIDX_W-1:0]   key_waddr;
    logic [KIDX_W-1:0]   key_raddr;
    logic [BYTE_W-1:0]   key_rdata;

    logic                in_xfer;
    logic                out_free;
    logic [KCNT_W-1:0]   kidx_inc;
    logic [KCNT_W-1:0]   key_len;
    logic [BYTE_W-1:0]   ks_byte;

    // Permutation and key byte storage.
    rc4_ram #(
        .DEPTH (PERM_SIZE),
        .WIDTH (BYTE_W)
    ) u_perm_ram (
        .clk   (clk),
        .we    (perm_we),
        .waddr (perm_waddr),
        .wdata (perm_wdata),
        .raddr (perm_raddr),
        .rdata (perm_rdata)
    );

    rc4_ram #(
        .DEPTH (KEY_MAX_BYTES),
        .WIDTH (BYTE_W)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (byte_in),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    // Handshake terms.
    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Key bytes are stored while the key count is below the limit.
    assign key_we    = in_xfer && (cmd == CMD_KEY) && (key_count_reg < KEY_MAX);
    assign key_waddr = key_count_reg[KIDX_W-1:0];
    assign key_raddr = kidx_reg;

    // Key index wraps at the key length; an empty key behaves as length one.
    assign kidx_inc = {1'b0, kidx_reg} + KCNT_W'(1);
    assign key_len  = (key_count_reg == '0) ? KCNT_W'(1) : key_count_reg;

    // Keystream byte with bypass for the two entries written by the swap.
    always_comb
    begin
        priority if (t_reg == j_reg)
        begin
            ks_byte = si_reg;
        end
        else if (t_reg == i_reg)
        begin
            ks_byte = sj_reg;
        end
        else
        begin
            ks_byte = perm_rdata;
        end
    end

    // Sequencer next-state and datapath logic.
    always_comb
    begin
        state_next     = state_reg;
        key_count_next = key_count_reg;
        kidx_next      = kidx_reg;
        n_next         = n_reg;
        acc_next       = acc_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        t_next         = t_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        b_next         = b_reg;
        res_next       = res_reg;
        res_nokey_next = res_nokey_reg;
        keyed_next     = keyed_reg;
        out_valid_next = out_valid_reg && out_stall;
        data_out_next  = data_out_reg;
        no_key_next    = no_key_reg;
        perm_we        = 1'b0;
        perm_waddr     = n_reg;
        perm_wdata     = si_reg;
        perm_raddr     = n_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    b_next = byte_in;
                    if (cmd == CMD_KEY)
                    begin
                        if (key_we)
                        begin
                            key_count_next = key_count_reg + KCNT_W'(1);
                        end
                        if (key_last)
                        begin
                            n_next     = '0;
                            state_next = S_INIT;
                        end
                    end
                    else if (keyed_reg)
                    begin
                        state_next = S_DRD1;
                    end
                    else
                    begin
                        res_next       = byte_in;
                        res_nokey_next = 1'b1;
                        state_next     = S_OUT;
                    end
                end
            end

            // Write the identity permutation, one entry per cycle.
            S_INIT:
            begin
                perm_we    = 1'b1;
                perm_waddr = n_reg;
                perm_wdata = n_reg;
                n_next     = n_reg + PIDX_W'(1);
                if (n_reg == PIDX_LAST)
                begin
                    n_next     = '0;
                    kidx_next  = '0;
                    acc_next   = '0;
                    state_next = S_KRD1;
                end
            end

            // Schedule step: read S[n] and the key byte.
            S_KRD1:
            begin
                perm_raddr = n_reg;
                state_next = S_KRD2;
            end

            // Update the accumulator and read S[acc].
            S_KRD2:
            begin
                acc_next   = acc_reg + perm_rdata + key_rdata;
                perm_raddr = acc_reg + perm_rdata + key_rdata;
                si_next    = perm_rdata;
                state_next = S_KWR1;
            end

            // Swap, first half: S[n] takes S[acc].
            S_KWR1:
            begin
                perm_we    = 1'b1;
                perm_waddr = n_reg;
                perm_wdata = perm_rdata;
                state_next = S_KWR2;
            end

            // Swap, second half: S[acc] takes old S[n]; advance the counters.
            S_KWR2:
            begin
                perm_we    = 1'b1;
                perm_waddr = acc_reg;
                perm_wdata = si_reg;
                n_next     = n_reg + PIDX_W'(1);
                kidx_next  = (kidx_inc == key_len) ? '0 : kidx_inc[KIDX_W-1:0];
                if (n_reg == PIDX_LAST)
                begin
                    i_next         = '0;
                    j_next         = '0;
                    keyed_next     = 1'b1;
                    key_count_next = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_KRD1;
                end
            end

            // Generator step: advance i and read S[i].
            S_DRD1:
            begin
                i_next     = i_reg + BYTE_W'(1);
                perm_raddr = i_reg + BYTE_W'(1);
                state_next = S_DRD2;
            end

            // Advance j and read S[j].
            S_DRD2:
            begin
                si_next    = perm_rdata;
                j_next     = j_reg + perm_rdata;
                perm_raddr = j_reg + perm_rdata;
                state_next = S_DWR1;
            end

            // S[i] takes S[j]; read the keystream entry before the swap ends.
            S_DWR1:
            begin
                sj_next    = perm_rdata;
                perm_we    = 1'b1;
                perm_waddr = i_reg;
                perm_wdata = perm_rdata;
                t_next     = si_reg + perm_rdata;
                perm_raddr = si_reg + perm_rdata;
                state_next = S_DWR2;
            end

            // S[j] takes old S[i]; form the result byte.
            S_DWR2:
            begin
                perm_we        = 1'b1;
                perm_waddr     = j_reg;
                perm_wdata     = si_reg;
                res_next       = b_reg ^ ks_byte;
                res_nokey_next = 1'b0;
                state_next     = S_OUT;
            end

            // Hand the result to the output register once it is free.
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    data_out_next  = res_reg;
                    no_key_next    = res_nokey_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, indices, key count, keyed flag and the output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_count_reg <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            keyed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_count_reg <= key_count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            keyed_reg     <= keyed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        kidx_reg      <= kidx_next;
        n_reg         <= n_next;
        acc_reg       <= acc_next;
        t_reg         <= t_next;
        si_reg        <= si_next;
        sj_reg        <= sj_next;
        b_reg         <= b_next;
        res_reg       <= res_next;
        res_nokey_reg <= res_nokey_next;
        data_out_reg  <= data_out_next;
        no_key_reg    <= no_key_next;
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign no_key    = no_key_reg;

endmodule

@@ dv/rc4_stream_cipher_tb.sv @@
// ---------------------------------------------------------------------------
// RC4 stream cipher testbench
// Drives key and data bytes into the cipher, predicts every output byte with
// an independent RC4 implementation and compares each result transfer field
// by field. The run starts with short directed sequences. Random keys follow,
// each with a run of data, some with data mixed into the key load. A key that
// fills the whole key store and runs past it comes last. The input idles and
// the output stalls at random, except in a quiet stretch.
// ---------------------------------------------------------------------------
module rc4_stream_cipher_tb;
    import rc4_pkg::*;

    localparam int KEY_MAX     = KEY_MAX_DEFAULT;
    localparam int RAND_ITEMS  = 300;
    localparam int IDLE_PCT    = 7;
    localparam int TAIL_CYCLES = 1400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_MAX   = 40;

    // One pending input transfer, or a pause until all results are back.
    typedef struct {
        bit    drain;
        cmd_t  op;
        byte_t val;
        logic  last;
    } cipher_req_t;

    // One expected output transfer.
    typedef struct {
        byte_t data;
        logic  nokey;
    } cipher_res_t;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  in_stall;
    logic  cmd       = CMD_KEY;
    byte_t byte_in   = '0;
    logic  key_last  = 1'b0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    byte_t data_out;
    logic  no_key;

    cipher_req_t req_q[$];
    cipher_res_t cipher_exp_q[$];

    // Predicted cipher state.
    byte_t       sbox [PERM_SIZE];
    byte_t       key_bytes [PERM_SIZE];
    int unsigned key_len;
    byte_t       idx_i;
    byte_t       idx_j;
    bit          have_key;

    bit          in_took;
    int unsigned cycle_cnt;
    int unsigned sent_cnt;
    int unsigned err_cnt;
    int unsigned checked_cnt;
    int unsigned sched_cnt;
    int unsigned cipher_cnt;
    int unsigned plain_cnt;
    int unsigned dropped_cnt;
    int unsigned longest_key;
    int unsigned drain_cnt;

    wire quiet = (sent_cnt >= 300) && (sent_cnt < 500);

    rc4_stream_cipher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .byte_in   (byte_in),
        .key_last  (key_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .no_key    (no_key)
    );

    // Clock and a single reset pulse at the start.
    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Count the failure and print a line while the log stays short.
    task automatic report_mismatch(string msg);
        err_cnt++;
        if (err_cnt <= PRINT_MAX)
            $display("MISMATCH cycle %0d: %s", cycle_cnt, msg);
    endtask

    // Advance the predicted cipher by one accepted input transfer.
    function automatic void rc4_predict(cmd_t op, byte_t val, logic last);
        cipher_res_t res;
        byte_t       acc;
        byte_t       tmp;
        int unsigned len;
        if (op == CMD_KEY)
        begin
            // Bytes past the store size are dropped.
            if (key_len < KEY_MAX)
            begin
                key_bytes[key_len] = val;
                key_len++;
            end
            else
                dropped_cnt++;
            if (last)
            begin
                len = (key_len == 0) ? 1 : key_len;
                for (int n = 0; n < PERM_SIZE; n++)
                    sbox[n] = byte_t'(n);
                acc = '0;
                for (int n = 0; n < PERM_SIZE; n++)
                begin
                    acc     = acc + sbox[n] + key_bytes[n % len];
                    tmp     = sbox[n];
                    sbox[n] = sbox[acc];
                    sbox[acc] = tmp;
                end
                if (key_len > longest_key)
                    longest_key = key_len;
                idx_i    = '0;
                idx_j    = '0;
                have_key = 1'b1;
                key_len  = 0;
                sched_cnt++;
            end
        end
        else if (!have_key)
        begin
            // No key scheduled yet: the byte comes back unchanged.
            res.data  = val;
            res.nokey = 1'b1;
            cipher_exp_q.push_back(res);
            plain_cnt++;
        end
        else
        begin
            idx_i       = idx_i + 8'd1;
            idx_j       = idx_j + sbox[idx_i];
            tmp         = sbox[idx_i];
            sbox[idx_i] = sbox[idx_j];
            sbox[idx_j] = tmp;
            res.data    = val ^ sbox[byte_t'(sbox[idx_i] + sbox[idx_j])];
            res.nokey   = 1'b0;
            cipher_exp_q.push_back(res);
            cipher_cnt++;
        end
    endfunction

    task automatic push_item(cmd_t op, byte_t val, logic last);
        cipher_req_t r;
        r.drain = 1'b0;
        r.op    = op;
        r.val   = val;
        r.last  = last;
        req_q.push_back(r);
    endtask

    task automatic push_drain();
        cipher_req_t r;
        r.drain = 1'b1;
        r.op    = CMD_KEY;
        r.val   = '0;
        r.last  = 1'b0;
        req_q.push_back(r);
    endtask

    // A random key; noise_pct mixes data bytes into the key load.
    task automatic push_key(int unsigned len, int unsigned noise_pct);
        for (int unsigned n = 0; n < len; n++)
        begin
            if ($urandom_range(99) < noise_pct)
                push_item(CMD_DATA, byte_t'($urandom), 1'($urandom));
            push_item(CMD_KEY, byte_t'($urandom), n == len - 1);
        end
    endtask

    // A run of random data bytes; key_last is random since data ignores it.
    task automatic push_data(int unsigned cnt);
        for (int unsigned n = 0; n < cnt; n++)
            push_item(CMD_DATA, byte_t'($urandom), 1'($urandom));
    endtask

    // Stimulus, end of run and verdict.
    initial
    begin
        int unsigned body_start;
        int unsigned len;
        for (int n = 0; n < PERM_SIZE; n++)
        begin
            sbox[n]      = byte_t'(n);
            key_bytes[n] = '0;
        end
        key_len  = 0;
        idx_i    = '0;
        idx_j    = '0;
        have_key = 1'b0;

        // Data ahead of any key passes through with no_key set.
        push_item(CMD_DATA, 8'h00, 1'b0);
        push_item(CMD_DATA, 8'hFF, 1'b1);
        // Shortest key, all zeros.
        push_item(CMD_KEY, 8'h00, 1'b1);
        push_item(CMD_DATA, 8'h00, 1'b0);
        push_item(CMD_DATA, 8'hFF, 1'b1);
        push_item(CMD_DATA, 8'hA5, 1'b0);
        // Shortest key, all ones.
        push_item(CMD_KEY, 8'hFF, 1'b1);
        push_item(CMD_DATA, 8'h5A, 1'b0);
        push_item(CMD_DATA, 8'hFF, 1'b0);
        // Text key "Key" over "Plain".
        push_item(CMD_KEY, 8'h4B, 1'b0);
        push_item(CMD_KEY, 8'h65, 1'b0);
        push_item(CMD_KEY, 8'h79, 1'b1);
        push_item(CMD_DATA, 8'h50, 1'b0);
        push_item(CMD_DATA, 8'h6C, 1'b0);
        push_item(CMD_DATA, 8'h61, 1'b0);
        push_item(CMD_DATA, 8'h69, 1'b0);
        push_item(CMD_DATA, 8'h6E, 1'b0);
        // Data during a new key load still uses the old schedule.
        push_item(CMD_KEY, 8'h01, 1'b0);
        push_item(CMD_DATA, 8'h3C, 1'b0);
        push_item(CMD_KEY, 8'h02, 1'b0);
        push_item(CMD_DATA, 8'hC3, 1'b1);
        push_item(CMD_KEY, 8'h80, 1'b1);
        push_item(CMD_DATA, 8'h00, 1'b0);
        push_drain();

        // Random keys, mostly short, each followed by a data run.
        body_start = req_q.size();
        while (req_q.size() - body_start < RAND_ITEMS)
        begin
            len = ($urandom_range(99) < 80) ? $urandom_range(16, 1) : $urandom_range(40, 17);
            push_key(len, ($urandom_range(9) == 0) ? 20 : 0);
            push_data($urandom_range(40, 1));
            if ($urandom_range(19) == 0)
                push_drain();
        end

        // A key that fills the key store and runs past it.
        push_drain();
        push_key(KEY_MAX + 2, 5);
        push_data(24);

        while (req_q.size() != 0 || in_valid)
            @(posedge clk);
        while (cipher_exp_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (cipher_exp_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", cipher_exp_q.size()));

        $display("Covered %0d key schedules (longest key %0d bytes, %0d extra bytes dropped),",
                 sched_cnt, longest_key, dropped_cnt);
        $display("%0d ciphered and %0d keyless bytes, %0d checked, %0d drain pauses.",
                 cipher_cnt, plain_cnt, checked_cnt, drain_cnt);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Input driver: holds a stalled transfer, otherwise sends or idles.
    always @(negedge clk)
    begin
        cipher_req_t nxt;
        bit          send;
        send = 1'b0;
        if (rst_n && (!in_valid || in_took))
        begin
            if (req_q.size() != 0 && req_q[0].drain)
            begin
                if (cipher_exp_q.size() == 0)
                begin
                    void'(req_q.pop_front());
                    drain_cnt++;
                end
            end
            else if (req_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
            begin
                nxt      = req_q.pop_front();
                send     = 1'b1;
                cmd      <= nxt.op;
                byte_in  <= nxt.val;
                key_last <= nxt.last;
                sent_cnt++;
            end
            in_valid <= send;
        end
    end

    // Output stall, random outside the quiet stretch.
    always @(negedge clk)
    begin
        if (rst_n)
            out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    // Monitor: checks result transfers, then feeds accepted inputs to the predictor.
    always @(posedge clk)
    begin
        cipher_res_t want;
        if (rst_n)
        begin
            if ($isunknown(out_valid) || $isunknown(in_stall))
                report_mismatch("handshake output is unknown");
            if (out_valid && !out_stall)
            begin
                if (cipher_exp_q.size() == 0)
                    report_mismatch($sformatf("unexpected result data_out=%02h no_key=%b",
                                              data_out, no_key));
                else
                begin
                    want = cipher_exp_q.pop_front();
                    if (data_out !== want.data)
                        report_mismatch($sformatf("data_out %02h, predicted %02h",
                                                  data_out, want.data));
                    if (no_key !== want.nokey)
                        report_mismatch($sformatf("no_key %b, predicted %b",
                                                  no_key, want.nokey));
                    checked_cnt++;
                end
            end
            in_took = in_valid && !in_stall;
            if (in_took)
                rc4_predict(cmd_t'(cmd), byte_in, key_last);
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule

@@ rc4_stream_cipher.f @@
hw/rtl/rc4_pkg.sv
hw/rtl/rc4_ram.sv
hw/rtl/rc4_stream_cipher.sv
dv/rc4_stream_cipher_tb.sv
